/* rtl/abde_pkg.sv */
package abde_pkg;

    localparam int CW = 14;   // signed coordinate width inside the engine

    localparam logic [2:0] CMD_BLEND = 3'd0;
    localparam logic [2:0] CMD_RECT  = 3'd1;
    localparam logic [2:0] CMD_LINE  = 3'd2;
    localparam logic [2:0] CMD_READ  = 3'd3;
    localparam logic [2:0] CMD_CLEAR = 3'd4;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        K_NOP,
        K_RECT,
        K_LINE,
        K_READ,
        K_CLEAR
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic signed [CW-1:0]   x0;
        logic signed [CW-1:0]   x1;
        logic signed [CW-1:0]   y0;
        logic signed [CW-1:0]   y1;
        logic signed [CW-1:0]   dx;
        logic signed [CW-1:0]   dy;
        logic signed [31:0]     dot0;
        logic signed [31:0]     crs0;
        logic signed [31:0]     len2;
        logic [47:0]            wl;
        logic [23:0]            color;
        logic [7:0]             alpha;
    } t_job;

    typedef struct packed {
        logic init_done;
    } t_back_stat;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CALC,
        F_PUSH
    } t_fstate;

    typedef enum logic [3:0] {
        B_INIT,
        B_IDLE,
        B_CLR,
        B_LTEST,
        B_LCHK,
        B_RD,
        B_MUL,
        B_WR,
        B_DONE
    } t_bstate;

endpackage

/* rtl/abde_front.sv */
module abde_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tvalid,
    output logic                 o_tready,
    input  logic [95:0]          i_tdata,
    input  logic [12:0]          i_act_w,
    input  logic [12:0]          i_act_h,
    input  abde_pkg::t_back_stat i_stat,
    output abde_pkg::t_job       o_job,
    output logic                 o_push,
    input  logic                 i_full
);

    abde_pkg::t_fstate r_state, n_state;

    logic [2:0]                        r_cmd;
    logic signed [abde_pkg::CW-1:0]    r_xs, r_ys, r_xe, r_ye;
    logic [7:0]                        r_lw;
    logic [23:0]                       r_color;
    logic [7:0]                        r_alpha;

    logic signed [abde_pkg::CW-1:0]    r_x0, r_x1, r_y0, r_y1, r_dx, r_dy;
    logic signed [31:0]                r_dot0, r_crs0, r_len2;
    logic [15:0]                       r_lw2;

    logic signed [abde_pkg::CW-1:0]    in_xs, in_ys, in_xe, in_ye, in_xe_s, in_ye_s;
    logic signed [abde_pkg::CW-1:0]    dx, dy, nxs, nys, xlo, xhi, ylo, yhi;
    logic signed [abde_pkg::CW-1:0]    wm1, hm1, cx0, cx1, cy0, cy1;
    logic signed [27:0]                p_dot_a, p_dot_b, p_crs_a, p_crs_b, p_dx2, p_dy2;
    logic                              rect_ok;
    logic                              accept;

    assign in_xs = abde_pkg::CW'($signed(i_tdata[15:3]));
    assign in_ys = abde_pkg::CW'($signed(i_tdata[28:16]));
    assign in_xe = abde_pkg::CW'($signed(i_tdata[41:29]));
    assign in_ye = abde_pkg::CW'($signed(i_tdata[54:42]));
    // single pixel commands behave as a one pixel rectangle
    assign in_xe_s = (i_tdata[2:0] == abde_pkg::CMD_BLEND || i_tdata[2:0] == abde_pkg::CMD_READ)
                     ? in_xs : in_xe;
    assign in_ye_s = (i_tdata[2:0] == abde_pkg::CMD_BLEND || i_tdata[2:0] == abde_pkg::CMD_READ)
                     ? in_ys : in_ye;

    assign o_tready = (r_state == abde_pkg::F_IDLE) && i_stat.init_done;
    assign accept   = o_tready && i_tvalid;

    assign dx  = r_xe - r_xs;
    assign dy  = r_ye - r_ys;
    assign nxs = -r_xs;
    assign nys = -r_ys;
    assign p_dot_a = nxs * dx;
    assign p_dot_b = nys * dy;
    assign p_crs_a = nxs * dy;
    assign p_crs_b = nys * dx;
    assign p_dx2   = dx * dx;
    assign p_dy2   = dy * dy;

    assign xlo = (r_xs < r_xe) ? r_xs : r_xe;
    assign xhi = (r_xs < r_xe) ? r_xe : r_xs;
    assign ylo = (r_ys < r_ye) ? r_ys : r_ye;
    assign yhi = (r_ys < r_ye) ? r_ye : r_ys;
    assign wm1 = $signed({1'b0, i_act_w}) - abde_pkg::CW'(1);
    assign hm1 = $signed({1'b0, i_act_h}) - abde_pkg::CW'(1);
    assign cx0 = (xlo < 0) ? '0 : xlo;
    assign cy0 = (ylo < 0) ? '0 : ylo;
    assign cx1 = (xhi > wm1) ? wm1 : xhi;
    assign cy1 = (yhi > hm1) ? hm1 : yhi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= abde_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_tdata[2:0];
            r_xs    <= in_xs;
            r_ys    <= in_ys;
            r_xe    <= in_xe_s;
            r_ye    <= in_ye_s;
            r_lw    <= i_tdata[62:55];
            r_color <= i_tdata[86:63];
            r_alpha <= i_tdata[94:87];
        end
        if (r_state == abde_pkg::F_CALC) begin
            r_dx   <= dx;
            r_dy   <= dy;
            r_dot0 <= 32'(p_dot_a + p_dot_b);
            r_crs0 <= 32'(p_crs_a - p_crs_b);
            r_len2 <= 32'(p_dx2 + p_dy2);
            r_lw2  <= r_lw * r_lw;
            r_x0   <= cx0;
            r_x1   <= cx1;
            r_y0   <= cy0;
            r_y1   <= cy1;
        end
    end

    assign rect_ok = (r_x0 <= r_x1) && (r_y0 <= r_y1);

    always_comb begin
        o_job       = '0;
        o_job.x0    = r_x0;
        o_job.x1    = r_x1;
        o_job.y0    = r_y0;
        o_job.y1    = r_y1;
        o_job.dx    = r_dx;
        o_job.dy    = r_dy;
        o_job.dot0  = r_dot0;
        o_job.crs0  = r_crs0;
        o_job.len2  = r_len2;
        o_job.wl    = 48'(r_lw2) * 48'(r_len2[27:0]);
        o_job.color = r_color;
        o_job.alpha = r_alpha;
        unique case (r_cmd)
            abde_pkg::CMD_BLEND, abde_pkg::CMD_RECT: begin
                o_job.kind = (r_alpha != 8'd0 && rect_ok) ? abde_pkg::K_RECT : abde_pkg::K_NOP;
            end
            abde_pkg::CMD_LINE: begin
                o_job.kind = (r_alpha != 8'd0 && r_len2 != 32'sd0 && i_act_w != 13'd0
                              && i_act_h != 13'd0) ? abde_pkg::K_LINE : abde_pkg::K_NOP;
                o_job.x0 = '0;
                o_job.y0 = '0;
                o_job.x1 = wm1;
                o_job.y1 = hm1;
            end
            abde_pkg::CMD_READ: begin
                o_job.kind = rect_ok ? abde_pkg::K_READ : abde_pkg::K_NOP;
            end
            abde_pkg::CMD_CLEAR: begin
                o_job.kind = abde_pkg::K_CLEAR;
            end
            default: begin
                o_job.kind = abde_pkg::K_NOP;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        unique case (r_state)
            abde_pkg::F_IDLE: begin
                if (accept) begin
                    n_state = abde_pkg::F_CALC;
                end
            end
            abde_pkg::F_CALC: begin
                n_state = abde_pkg::F_PUSH;
            end
            abde_pkg::F_PUSH: begin
                o_push = !i_full;
                if (!i_full) begin
                    n_state = abde_pkg::F_IDLE;
                end
            end
            default: begin
                n_state = abde_pkg::F_IDLE;
            end
        endcase
    end

endmodule

/* rtl/abde_queue.sv */
module abde_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  abde_pkg::t_job i_job,
    input  logic           i_pop,
    output abde_pkg::t_job o_job,
    output logic           o_full,
    output logic           o_empty
);

    abde_pkg::t_job r_slot [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

/* rtl/abde_back.sv */
module abde_back #(
    parameter int FB_WIDTH  = 256,
    parameter int FB_HEIGHT = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  abde_pkg::t_job       i_job,
    input  logic                 i_empty,
    output logic                 o_pop,
    output abde_pkg::t_back_stat o_stat,
    output logic                 o_tvalid,
    input  logic                 i_tready,
    output logic [31:0]          o_tdata
);

    localparam int DEPTH = FB_WIDTH * FB_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    abde_pkg::t_bstate r_state, n_state;
    abde_pkg::t_job    r_job;

    logic [23:0]                    r_mem [DEPTH];
    logic [23:0]                    r_rdata;
    logic [AW-1:0]                  r_caddr;
    logic signed [abde_pkg::CW-1:0] r_x, r_y;
    logic signed [31:0]             r_dot, r_crs, r_dot_row, r_crs_row;
    logic [63:0]                    r_sq;
    logic                           r_dok;
    logic [16:0]                    r_sum [3];
    logic [24:0]                    r_res;
    logic                           r_ovalid;
    logic [31:0]                    r_odata;

    logic [31:0]   pix_lin;
    logic [AW-1:0] a_cur, a_mem;
    logic          we;
    logic [23:0]   wdata, blended;
    logic          last_x, last_px;
    logic          out_free;
    logic [16:0]   q_tmp [3];
    logic [7:0]    dst_c [3];
    logic [7:0]    src_c [3];

    assign pix_lin = 32'(r_y[12:0]) * 32'(FB_WIDTH) + 32'(r_x[12:0]);
    assign a_cur   = pix_lin[AW-1:0];
    assign a_mem   = (r_state == abde_pkg::B_INIT || r_state == abde_pkg::B_CLR) ? r_caddr : a_cur;

    assign o_stat.init_done = (r_state != abde_pkg::B_INIT);
    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_odata;
    assign out_free = !r_ovalid || i_tready;

    assign last_x  = (r_x == r_job.x1);
    assign last_px = last_x && (r_y == r_job.y1);

    // per channel: (dst*(255-a) + src*a + 127) / 255, the divide as a shift form
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            dst_c[c] = r_rdata[8*c +: 8];
            src_c[c] = r_job.color[8*c +: 8];
            q_tmp[c] = (r_sum[c] + 17'(r_sum[c][16:8]) + 17'd1) >> 8;
            blended[8*c +: 8] = q_tmp[c][7:0];
        end
    end

    always_comb begin
        we    = 1'b0;
        wdata = blended;
        if (r_state == abde_pkg::B_INIT) begin
            we    = 1'b1;
            wdata = '0;
        end else if (r_state == abde_pkg::B_CLR) begin
            we    = 1'b1;
            wdata = r_job.color;
        end else if (r_state == abde_pkg::B_WR) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[a_mem] <= wdata;
        end
        r_rdata <= r_mem[a_mem];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= abde_pkg::B_INIT;
            r_caddr  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == abde_pkg::B_INIT || r_state == abde_pkg::B_CLR) begin
                r_caddr <= r_caddr + AW'(1);
            end else begin
                r_caddr <= '0;
            end
            if (r_state == abde_pkg::B_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // walk over the pixel range, dot and cross products stepped per pixel
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job     <= i_job;
            r_x       <= i_job.x0;
            r_y       <= i_job.y0;
            r_dot     <= i_job.dot0;
            r_dot_row <= i_job.dot0;
            r_crs     <= i_job.crs0;
            r_crs_row <= i_job.crs0;
            r_res     <= '0;
        end
        if (r_state == abde_pkg::B_LTEST) begin
            r_sq  <= 64'(64'(r_crs) * 64'(r_crs));
            r_dok <= (r_dot >= 32'sd0) && (r_dot <= r_job.len2);
        end
        if (r_state == abde_pkg::B_MUL) begin
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= 17'(dst_c[c]) * 17'(8'd255 - r_job.alpha)
                          + 17'(src_c[c]) * 17'(r_job.alpha) + 17'd127;
            end
            if (r_job.kind == abde_pkg::K_READ) begin
                r_res <= {1'b1, r_rdata};
            end
        end
        if ((r_state == abde_pkg::B_WR
             || (r_state == abde_pkg::B_LCHK && !(r_dok && (r_sq << 2) <= 64'(r_job.wl))))
            && !last_px) begin
            if (last_x) begin
                r_x       <= r_job.x0;
                r_y       <= r_y + abde_pkg::CW'(1);
                r_dot     <= r_dot_row + 32'(r_job.dy);
                r_dot_row <= r_dot_row + 32'(r_job.dy);
                r_crs     <= r_crs_row - 32'(r_job.dx);
                r_crs_row <= r_crs_row - 32'(r_job.dx);
            end else begin
                r_x   <= r_x + abde_pkg::CW'(1);
                r_dot <= r_dot + 32'(r_job.dx);
                r_crs <= r_crs + 32'(r_job.dy);
            end
        end
        if (r_state == abde_pkg::B_DONE && out_free) begin
            r_odata <= {7'd0, r_res};
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            abde_pkg::B_INIT, abde_pkg::B_CLR: begin
                if (r_caddr == AW'(DEPTH - 1)) begin
                    n_state = (r_state == abde_pkg::B_INIT) ? abde_pkg::B_IDLE
                                                            : abde_pkg::B_DONE;
                end
            end
            abde_pkg::B_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    unique case (i_job.kind)
                        abde_pkg::K_RECT, abde_pkg::K_READ: n_state = abde_pkg::B_RD;
                        abde_pkg::K_LINE:  n_state = abde_pkg::B_LTEST;
                        abde_pkg::K_CLEAR: n_state = abde_pkg::B_CLR;
                        default:           n_state = abde_pkg::B_DONE;
                    endcase
                end
            end
            abde_pkg::B_LTEST: begin
                n_state = abde_pkg::B_LCHK;
            end
            abde_pkg::B_LCHK: begin
                if (r_dok && (r_sq << 2) <= 64'(r_job.wl)) begin
                    n_state = abde_pkg::B_RD;
                end else if (last_px) begin
                    n_state = abde_pkg::B_DONE;
                end else begin
                    n_state = abde_pkg::B_LTEST;
                end
            end
            abde_pkg::B_RD: begin
                n_state = abde_pkg::B_MUL;
            end
            abde_pkg::B_MUL: begin
                n_state = (r_job.kind == abde_pkg::K_READ) ? abde_pkg::B_DONE : abde_pkg::B_WR;
            end
            abde_pkg::B_WR: begin
                if (last_px) begin
                    n_state = abde_pkg::B_DONE;
                end else begin
                    n_state = (r_job.kind == abde_pkg::K_LINE) ? abde_pkg::B_LTEST
                                                               : abde_pkg::B_RD;
                end
            end
            abde_pkg::B_DONE: begin
                if (out_free) begin
                    n_state = abde_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = abde_pkg::B_IDLE;
            end
        endcase
    end

endmodule

/* rtl/alpha_blend_draw_engine_unit.sv */
// channel    direction  ports                       contents
// s_axis     in         s_axis_tvalid/tready/tdata  one draw command word
// m_axis     out        m_axis_tvalid/tready/tdata  one result word per command
// cfg        in         i_cfg_we/i_cfg_idx/i_cfg_data  active width, active height
//
// steps: a blend or rectangle pixel is read, blended and written back, a read pixel
// is only read, a line pixel is tested first and drawn only if in the stroke, a clear
// writes every store entry, all through the single read-modify-write port of the pixel store
// reset: a clearing pass over all FB_WIDTH*FB_HEIGHT entries zeroes the store, no word
// is taken until it ends
// stalls: a two entry queue parts command decode from drawing, an output
// register holds the result while the next command is decoded
module alpha_blend_draw_engine_unit #(
    parameter int FB_WIDTH  = 256,
    parameter int FB_HEIGHT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd, x_start, y_start, x_end, y_end, line_width, red, green, blue, opacity
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_red, read_green, read_blue, in_bounds
    output logic [31:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [8:0]  i_cfg_data
);

    logic [8:0]  r_act_w, r_act_h;
    logic [12:0] act_w, act_h;

    abde_pkg::t_job       push_job, head_job;
    abde_pkg::t_back_stat stat;
    logic                 push, pop, full, empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_w <= 9'd256;
            r_act_h <= 9'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                abde_pkg::REG_WIDTH:  r_act_w <= i_cfg_data;
                abde_pkg::REG_HEIGHT: r_act_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign act_w = (32'(r_act_w) > FB_WIDTH)  ? 13'(FB_WIDTH)  : 13'(r_act_w);
    assign act_h = (32'(r_act_h) > FB_HEIGHT) ? 13'(FB_HEIGHT) : 13'(r_act_h);

    abde_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_act_w  (act_w),
        .i_act_h  (act_h),
        .i_stat   (stat),
        .o_job    (push_job),
        .o_push   (push),
        .i_full   (full)
    );

    abde_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (full),
        .o_empty (empty)
    );

    abde_back #(
        .FB_WIDTH  (FB_WIDTH),
        .FB_HEIGHT (FB_HEIGHT)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (head_job),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_stat   (stat),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata)
    );

endmodule
